// ===== rtl/spr_pkg.sv =====
// Shared types and constants for the stepper pace ramp controller.
package spr_pkg;

  localparam int PACE_IO_W   = 24;
  localparam int MSTEP_W     = 3;
  localparam int RELOAD_W    = 19;
  localparam int ACCEL_W     = 16;
  localparam int JUMP_W      = 12;
  localparam int RPM_W       = 12;
  localparam int IDX_W       = 8;
  localparam int INCR_W      = 13;
  localparam int DIV_W       = 19;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam int RPM_NUMER   = 300000;
  localparam int PACE_FLOOR  = 100;
  localparam int MSTEP_LIMIT = 1400;
  localparam int MSTEP_MAX   = 4;
  localparam int ACCEL_RESET = 50000;
  localparam int JUMP_RESET  = 180;

  // x / 10 for 16-bit x as (x * 52429) >> 19, exact over the whole range.
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;

  // Register index, taken from paddr[2].
  localparam logic REG_ACCEL = 1'b0;
  localparam logic REG_JUMP  = 1'b1;

  typedef enum logic [2:0] {
    OP_RPM_NEW = 3'd0,
    OP_RPM_CUR = 3'd1,
    OP_END     = 3'd2,
    OP_IDX     = 3'd3,
    OP_TICK    = 3'd4
  } div_op_t;

  typedef enum logic [1:0] {
    SRC_REQ  = 2'd0,
    SRC_QUOT = 2'd1,
    SRC_TGT  = 2'd2
  } apply_src_t;

  typedef struct packed {
    logic       load_item;
    logic       div_start;
    div_op_t    div_op;
    logic       apply_en;
    apply_src_t apply_src;
    logic       ramp_set;
    logic       ramp_clr;
    logic       idx_inc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic item_tick;
    logic ramp_active;
    logic tick_in_range;
    logic rise_big;
    logic div_busy;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/spr_ifs.sv =====
// Valid/ready channel interfaces for pace items and result items.
interface spr_in_if import spr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [PACE_IO_W-1:0] pace;

  modport source (output valid, output mode, output pace, input ready);
  modport sink   (input valid, input mode, input pace, output ready);
endinterface

interface spr_out_if import spr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PACE_IO_W-1:0] applied_pace;
  logic [MSTEP_W-1:0]   microstep_mode;
  logic                 motor_enabled;
  logic [RELOAD_W-1:0]  reload_value;
  logic                 ramp_busy;
  logic                 pace_changed;

  modport source (output valid, output applied_pace, output microstep_mode,
                  output motor_enabled, output reload_value, output ramp_busy,
                  output pace_changed, input ready);
  modport sink   (input valid, input applied_pace, input microstep_mode,
                  input motor_enabled, input reload_value, input ramp_busy,
                  input pace_changed, output ready);
endinterface

// ===== rtl/spr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module spr_div import spr_pkg::*; #(
  parameter int PACE_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [PACE_WIDTH-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]      dvd_r;
  logic [PACE_WIDTH-1:0] rem_r;
  logic [PACE_WIDTH-1:0] dsr_r;
  logic [PACE_WIDTH:0]   trial;
  logic                  qbit;
  logic [PACE_WIDTH-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DIV_W-1]};
    qbit    = (trial >= {1'b0, dsr_r});
    rem_nxt = qbit ? PACE_WIDTH'(trial - {1'b0, dsr_r}) : trial[PACE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts out its top bit and takes in quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== rtl/spr_datapath.sv =====
// Datapath: pace and ramp state, shared divider, pace application and result register.
module spr_datapath import spr_pkg::*; #(
  parameter int PACE_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_mode,
  input  logic [PACE_IO_W-1:0] in_pace,
  input  logic [ACCEL_W-1:0]   accel_rate,
  input  logic [JUMP_W-1:0]    max_rpm_jump,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic [PACE_IO_W-1:0] out_pace,
  output logic [MSTEP_W-1:0]   out_mstep,
  output logic                 out_enabled,
  output logic [RELOAD_W-1:0]  out_reload,
  output logic                 out_busy,
  output logic                 out_changed
);

  logic                  item_tick_r;
  logic [PACE_WIDTH-1:0] item_pace_r;

  logic [PACE_WIDTH-1:0] current_pace_r;
  logic                  stopped_r;
  logic                  ramp_active_r;
  logic [IDX_W-1:0]      ramp_index_r;
  logic [IDX_W-1:0]      ramp_end_r;
  logic [PACE_WIDTH-1:0] ramp_target_r;
  logic [MSTEP_W-1:0]    step_mode_r;
  logic [RELOAD_W-1:0]   reload_r;
  logic                  changed_r;

  div_op_t               op_r;
  logic                  guard_r;
  logic [RPM_W-1:0]      rpm_new_r;
  logic [RPM_W-1:0]      rpm_cur_r;
  logic [IDX_W-1:0]      q_end_r;

  logic [PACE_IO_W-1:0]  out_pace_r;
  logic [MSTEP_W-1:0]    out_mstep_r;
  logic                  out_enabled_r;
  logic [RELOAD_W-1:0]   out_reload_r;
  logic                  out_busy_r;
  logic                  out_changed_r;

  logic [31:0]           incr_prod;
  logic [INCR_W-1:0]     incr;
  logic [DIV_W-1:0]      div_dvd;
  logic [PACE_WIDTH-1:0] div_dsr;
  logic                  div_guard;
  logic                  div_busy;
  logic                  div_done;
  logic [DIV_W-1:0]      div_q;
  logic [DIV_W-1:0]      q_eff;

  logic [PACE_WIDTH-1:0] apply_src;
  logic [PACE_WIDTH-1:0] halved;
  logic [MSTEP_W-1:0]    apply_mode;
  logic                  mode_found;
  logic                  apply_stop;
  logic [RELOAD_W-1:0]   apply_reload;

  assign incr_prod = 32'(accel_rate) * 32'(DIV10_MUL);
  assign incr      = incr_prod[DIV10_SHIFT +: INCR_W];

  always_comb begin
    div_dvd = DIV_W'(RPM_NUMER);
    div_dsr = item_pace_r;
    case (cmd.div_op)
      OP_RPM_NEW: begin
        div_dvd = DIV_W'(RPM_NUMER);
        div_dsr = item_pace_r;
      end
      OP_RPM_CUR: begin
        div_dvd = DIV_W'(RPM_NUMER);
        div_dsr = current_pace_r;
      end
      OP_END: begin
        div_dvd = DIV_W'(incr);
        div_dsr = item_pace_r;
      end
      OP_IDX: begin
        div_dvd = DIV_W'(incr);
        div_dsr = current_pace_r;
      end
      OP_TICK: begin
        div_dvd = DIV_W'(incr);
        div_dsr = PACE_WIDTH'(ramp_index_r);
      end
      default: begin
        div_dvd = DIV_W'(RPM_NUMER);
        div_dsr = item_pace_r;
      end
    endcase
    // Speed and ramp bounds read as zero for a pace below the minimum.
    div_guard = (cmd.div_op != OP_TICK) && (div_dsr < PACE_WIDTH'(PACE_FLOOR));
  end

  spr_div #(
    .PACE_WIDTH (PACE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_eff = guard_r ? '0 : div_q;

  always_comb begin
    apply_src = item_pace_r;
    case (cmd.apply_src)
      SRC_REQ:  apply_src = item_pace_r;
      SRC_QUOT: apply_src = PACE_WIDTH'(q_eff[INCR_W-1:0]);
      SRC_TGT:  apply_src = ramp_target_r;
      default:  apply_src = item_pace_r;
    endcase
  end

  // Halve until below the microstep limit, at most four times.
  always_comb begin
    halved     = apply_src;
    apply_mode = MSTEP_W'(MSTEP_MAX);
    mode_found = 1'b0;
    for (int i = 0; i < MSTEP_MAX; i++) begin
      if (!mode_found) begin
        if (halved < PACE_WIDTH'(MSTEP_LIMIT)) begin
          apply_mode = MSTEP_W'(i);
          mode_found = 1'b1;
        end else begin
          halved = halved >> 1;
        end
      end
    end
    apply_stop   = (halved <= PACE_WIDTH'(PACE_FLOOR));
    apply_reload = RELOAD_W'((halved >> 1) - PACE_WIDTH'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_tick_r <= in_mode;
      item_pace_r <= PACE_WIDTH'(in_pace);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      op_r    <= cmd.div_op;
      guard_r <= div_guard;
    end
    if (div_done) begin
      case (op_r)
        OP_RPM_NEW: rpm_new_r <= q_eff[RPM_W-1:0];
        OP_RPM_CUR: rpm_cur_r <= q_eff[RPM_W-1:0];
        OP_END:     q_end_r   <= q_eff[IDX_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_pace_r <= '0;
      stopped_r      <= 1'b1;
      ramp_active_r  <= 1'b0;
      ramp_index_r   <= '0;
      ramp_end_r     <= '0;
      ramp_target_r  <= '0;
      step_mode_r    <= '0;
      reload_r       <= '0;
      changed_r      <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        changed_r <= 1'b0;
      end
      if (cmd.apply_en) begin
        current_pace_r <= apply_src;
        step_mode_r    <= apply_mode;
        stopped_r      <= apply_stop;
        changed_r      <= 1'b1;
        if (!apply_stop) begin
          reload_r <= apply_reload;
        end
      end
      if (cmd.ramp_clr) begin
        ramp_active_r <= 1'b0;
      end
      if (cmd.ramp_set) begin
        ramp_active_r <= 1'b1;
        ramp_target_r <= item_pace_r;
        ramp_end_r    <= q_end_r;
        ramp_index_r  <= q_eff[IDX_W-1:0] + IDX_W'(1);
      end
      if (cmd.idx_inc) begin
        ramp_index_r <= ramp_index_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pace_r    <= PACE_IO_W'(current_pace_r);
      out_mstep_r   <= step_mode_r;
      out_enabled_r <= !stopped_r;
      out_reload_r  <= reload_r;
      out_busy_r    <= ramp_active_r;
      out_changed_r <= changed_r;
    end
  end

  always_comb begin
    stat.item_tick     = item_tick_r;
    stat.ramp_active   = ramp_active_r;
    stat.tick_in_range = (ramp_index_r < ramp_end_r) && (ramp_index_r != '0);
    stat.rise_big      = ({1'b0, rpm_new_r} >
                          ({1'b0, rpm_cur_r} + (RPM_W + 1)'(max_rpm_jump)));
    stat.div_busy      = div_busy;
    stat.div_done      = div_done;
  end

  assign out_pace    = out_pace_r;
  assign out_mstep   = out_mstep_r;
  assign out_enabled = out_enabled_r;
  assign out_reload  = out_reload_r;
  assign out_busy    = out_busy_r;
  assign out_changed = out_changed_r;

endmodule

// ===== rtl/spr_ctrl.sv =====
// Controller: sequences the divisions, pace updates and result transfer of one item.
module spr_ctrl import spr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DECODE   = 9'b000000010,
    ST_DIV_NEW  = 9'b000000100,
    ST_DIV_CUR  = 9'b000001000,
    ST_CMP      = 9'b000010000,
    ST_DIV_END  = 9'b000100000,
    ST_DIV_IDX  = 9'b001000000,
    ST_DIV_TICK = 9'b010000000,
    ST_DONE     = 9'b100000000
  } st_t;

  st_t  state_r;
  st_t  state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_op    = OP_RPM_NEW;
    cmd.apply_src = SRC_REQ;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!stat.item_tick) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_RPM_NEW;
          state_nxt     = ST_DIV_NEW;
        end else if (stat.ramp_active) begin
          if (stat.tick_in_range) begin
            cmd.div_start = 1'b1;
            cmd.div_op    = OP_TICK;
            state_nxt     = ST_DIV_TICK;
          end else begin
            // Past the last index, or with the index at zero, the ramp lands on its target pace.
            cmd.apply_en  = 1'b1;
            cmd.apply_src = SRC_TGT;
            cmd.ramp_clr  = 1'b1;
            state_nxt     = ST_DONE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV_NEW: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_RPM_CUR;
          state_nxt     = ST_DIV_CUR;
        end
      end
      ST_DIV_CUR: begin
        if (stat.div_done) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat.rise_big) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_END;
          state_nxt     = ST_DIV_END;
        end else begin
          cmd.apply_en  = 1'b1;
          cmd.apply_src = SRC_REQ;
          cmd.ramp_clr  = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DIV_END: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_IDX;
          state_nxt     = ST_DIV_IDX;
        end
      end
      ST_DIV_IDX: begin
        if (stat.div_done) begin
          cmd.div_op   = OP_IDX;
          cmd.ramp_set = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DIV_TICK: begin
        if (stat.div_done) begin
          cmd.div_op    = OP_TICK;
          cmd.apply_en  = 1'b1;
          cmd.apply_src = SRC_QUOT;
          cmd.idx_inc   = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/stepper_pace_ramp_controller.sv =====
// A tick outside a ramp needs no division, a ramp tick inside the ramp needs one, a request
// applied at once needs two and a request that starts a ramp needs four. Every division
// runs on the one shared 19-step serial divider. One item is in work at a time; the result
// register lets the next item enter while a result waits. Synchronous active-low reset
// stops the motor, clears pace and ramp state and loads the register defaults.
module stepper_pace_ramp_controller import spr_pkg::*; #(
  parameter int PACE_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  spr_in_if.sink            in_ch,
  spr_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [ACCEL_W-1:0] accel_r;
  logic [JUMP_W-1:0]  jump_r;
  logic               cfg_wr;
  cmd_t               cmd;
  stat_t              stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= ACCEL_W'(ACCEL_RESET);
      jump_r  <= JUMP_W'(JUMP_RESET);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACCEL: accel_r <= pwdata[ACCEL_W-1:0];
        REG_JUMP:  jump_r  <= pwdata[JUMP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACCEL: prdata = CFG_DW'(accel_r);
      REG_JUMP:  prdata = CFG_DW'(jump_r);
      default:   prdata = '0;
    endcase
  end

  spr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spr_datapath #(
    .PACE_WIDTH (PACE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_ch.mode),
    .in_pace      (in_ch.pace),
    .accel_rate   (accel_r),
    .max_rpm_jump (jump_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_pace     (out_ch.applied_pace),
    .out_mstep    (out_ch.microstep_mode),
    .out_enabled  (out_ch.motor_enabled),
    .out_reload   (out_ch.reload_value),
    .out_busy     (out_ch.ramp_busy),
    .out_changed  (out_ch.pace_changed)
  );

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while a division is in progress");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while one is in work");

  a_mstep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.microstep_mode <= MSTEP_W'(MSTEP_MAX)))
    else $error("microstep mode out of range");
`endif

endmodule
